// File: rtl/core/utf8_to_utf16_decoder_defines.svh
// ---------------------------------------------------------------------------
// utf8_to_utf16_decoder assertion macros
// Concurrent check wrappers shared by the decoder modules.
// ---------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_DECODER_DEFINES_SVH
`define UTF8_TO_UTF16_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define U8U16_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("u8u16 assertion failed");
`define U8U16_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("u8u16 reset assertion failed");
`else
`define U8U16_ASSERT(lbl, clk, rst, prop)
`define U8U16_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// File: rtl/core/u8u16_pkg.sv
// ---------------------------------------------------------------------------
// u8u16_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder.
// ---------------------------------------------------------------------------
package u8u16_pkg;

  localparam logic [15:0] REPL_UNIT     = 16'hFFFD;
  localparam logic [15:0] HI_SURR_BASE  = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE  = 16'hDC00;
  localparam logic [20:0] SUPP_BASE     = 21'h010000;
  localparam logic [20:0] CODE_LIMIT    = 21'h110000;
  localparam logic [20:0] SURR_FIRST    = 21'h00D800;
  localparam logic [20:0] SURR_LAST     = 21'h00DFFF;
  localparam logic [7:0]  CONT_MARK     = 8'h80;
  localparam int          CONT_BITS     = 6;

  // continuation checks, on the value collected so far
  localparam logic [20:0] LIMIT_PART     = CODE_LIMIT >> CONT_BITS;
  localparam logic [20:0] SURR_PART_LO   = SURR_FIRST >> CONT_BITS;
  localparam logic [20:0] SURR_PART_HI   = SURR_LAST >> CONT_BITS;
  localparam logic [20:0] OVERLONG3_PART = 21'h20;
  localparam logic [20:0] OVERLONG4_PART = 21'h10;
  localparam logic [20:0] OVERLONG2_VAL  = 21'h80;
  localparam logic [20:0] BMP_MAX        = 21'h00FFFF;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic [2:0] bytes_left;
  } in_word_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_of_run;
  } out_word_t;

  // what one byte asks of the back end
  typedef enum logic [2:0] {
    OP_NONE,
    OP_UNIT,
    OP_PAIR,
    OP_REPL,
    OP_REPL_UNIT,
    OP_REPL_REPL
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [20:0] value;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } push_t;

  typedef struct packed {
    logic avail;
    job_t job;
  } head_t;

endpackage

// File: rtl/core/utf8_to_utf16_decoder.sv
// ---------------------------------------------------------------------------
// utf8_to_utf16_decoder
// UTF-8 byte stream to UTF-16 words, bad sequences replaced by U+FFFD.
//
//   channel  dir  handshake                 word
//   byte     in   byte_valid / byte_stall   in_word_t  (data_byte, bytes_left)
//   unit     out  unit_valid / unit_stall   out_word_t (code_unit, last_of_run)
//
// One byte is taken per cycle while the four-entry job queue has room.
// Each word is one output handshake; a byte that yields two words
// holds its queue entry until its second word is taken.
// A job is registered in the queue before it reaches the output.
// Synchronous reset clears the sequence state, queue and second-word flag.
// Output stall backs up into the queue only; byte_stall is queue full.
// ---------------------------------------------------------------------------
module utf8_to_utf16_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  u8u16_pkg::in_word_t  byte_word,
  output logic                 unit_valid,
  input  logic                 unit_stall,
  output u8u16_pkg::out_word_t unit_word
);
  import u8u16_pkg::*;

  push_t push;
  head_t head;
  logic  q_full;
  logic  pop;

  u8u16_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .q_full     (q_full),
    .push       (push)
  );

  u8u16_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .pop        (pop),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_word  (unit_word)
  );

endmodule

// File: rtl/core/u8u16_front.sv
// ---------------------------------------------------------------------------
// u8u16_front
// Takes source bytes, tracks the pending sequence and classifies each byte
// into a job for the back end.
// ---------------------------------------------------------------------------
module u8u16_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  u8u16_pkg::in_word_t byte_word,
  input  logic                q_full,
  output u8u16_pkg::push_t    push
);
  import u8u16_pkg::*;

  logic        seq_active, seq_active_next;
  logic [1:0]  conts_needed, conts_needed_next;
  logic [20:0] partial_value, partial_value_next;

  logic [7:0]  b;
  logic [7:0]  low;
  logic [20:0] v;
  logic        accept;
  logic        is_ascii;
  logic [1:0]  lead_len;
  logic [20:0] lead_bits;
  logic        lead_start;
  op_t         lead_op;
  op_t         relead_op;
  op_t         op;

  assign byte_stall = q_full;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    b   = byte_word.data_byte;
    low = b ^ CONT_MARK;
    v   = {partial_value[14:0], low[5:0]};

    is_ascii  = (b < 8'h80);
    lead_len  = 2'd0;
    lead_bits = '0;
    if (b inside {[8'hC2:8'hDF]}) begin
      lead_len  = 2'd1;
      lead_bits = {16'd0, b[4:0]};
    end else if (b inside {[8'hE0:8'hEF]}) begin
      lead_len  = 2'd2;
      lead_bits = {17'd0, b[3:0]};
    end else if (b inside {[8'hF0:8'hF4]}) begin
      lead_len  = 2'd3;
      lead_bits = {18'd0, b[2:0]};
    end
    lead_start = (lead_len != 2'd0) && (byte_word.bytes_left > {1'b0, lead_len});

    if (is_ascii) begin
      lead_op   = OP_UNIT;
      relead_op = OP_REPL_UNIT;
    end else if (lead_start) begin
      lead_op   = OP_NONE;
      relead_op = OP_REPL;
    end else begin
      lead_op   = OP_REPL;
      relead_op = OP_REPL_REPL;
    end

    op                 = OP_NONE;
    seq_active_next    = seq_active;
    conts_needed_next  = conts_needed;
    partial_value_next = partial_value;

    if (!seq_active || low[7:6] != 2'b00 ||
        (conts_needed == 2'd2 && v >= LIMIT_PART)) begin
      // fresh lead, or a rejected continuation handled again as a lead
      op                 = seq_active ? relead_op : lead_op;
      seq_active_next    = lead_start;
      conts_needed_next  = lead_start ? lead_len : 2'd0;
      partial_value_next = lead_start ? lead_bits : '0;
    end else begin
      case (conts_needed)
        2'd3: begin
          if (v < OVERLONG4_PART) begin
            op                 = OP_REPL;
            seq_active_next    = 1'b0;
            conts_needed_next  = 2'd0;
            partial_value_next = '0;
          end else begin
            conts_needed_next  = 2'd2;
            partial_value_next = v;
          end
        end
        2'd2: begin
          if (v < OVERLONG3_PART || (v >= SURR_PART_LO && v <= SURR_PART_HI)) begin
            op                 = OP_REPL;
            seq_active_next    = 1'b0;
            conts_needed_next  = 2'd0;
            partial_value_next = '0;
          end else begin
            conts_needed_next  = 2'd1;
            partial_value_next = v;
          end
        end
        default: begin
          seq_active_next    = 1'b0;
          conts_needed_next  = 2'd0;
          partial_value_next = '0;
          if (v < OVERLONG2_VAL) begin
            op = OP_REPL;
          end else if (v <= BMP_MAX) begin
            op = OP_UNIT;
          end else begin
            op = OP_PAIR;
          end
        end
      endcase
    end

    push.push      = accept && (op != OP_NONE);
    push.job.op    = op;
    push.job.value = (seq_active && low[7:6] == 2'b00 &&
                      !(conts_needed == 2'd2 && v >= LIMIT_PART)) ? v : {13'd0, b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_active    <= 1'b0;
      conts_needed  <= 2'd0;
      partial_value <= '0;
    end else if (accept) begin
      seq_active    <= seq_active_next;
      conts_needed  <= conts_needed_next;
      partial_value <= partial_value_next;
    end
  end

endmodule

// File: rtl/core/u8u16_queue.sv
// ---------------------------------------------------------------------------
// u8u16_queue
// Short job queue between the classifier and the unit emitter.
// ---------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_defines.svh"

module u8u16_queue (
  input  logic              clk,
  input  logic              rst,
  input  u8u16_pkg::push_t  push,
  input  logic              pop,
  output u8u16_pkg::head_t  head,
  output logic              full
);
  import u8u16_pkg::*;

  job_t               slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               empty;

  assign empty      = (count == '0);
  assign full       = (count == Q_CNT_W'(Q_DEPTH));
  assign head.avail = !empty;
  assign head.job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.push) begin
      slots[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `U8U16_ASSERT(no_push_full, clk, rst, !(push.push && full))
  `U8U16_ASSERT(no_pop_empty, clk, rst, !(pop && empty))
  `U8U16_ASSERT_RST(empty_after_rst, clk, rst |=> (count == '0 && rd_ptr == wr_ptr))

endmodule

// File: rtl/core/u8u16_back.sv
// ---------------------------------------------------------------------------
// u8u16_back
// Expands queued jobs into UTF-16 words, one word per handshake.
// ---------------------------------------------------------------------------
`include "utf8_to_utf16_decoder_defines.svh"

module u8u16_back (
  input  logic                 clk,
  input  logic                 rst,
  input  u8u16_pkg::head_t     head,
  output logic                 pop,
  output logic                 unit_valid,
  input  logic                 unit_stall,
  output u8u16_pkg::out_word_t unit_word
);
  import u8u16_pkg::*;

  logic        half;
  logic        accept;
  logic [20:0] offset;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit;

  assign unit_valid = head.avail;
  assign accept     = unit_valid && !unit_stall;
  assign pop        = accept && unit_word.last_of_run;

  always_comb begin
    offset  = head.job.value - SUPP_BASE;
    hi_unit = HI_SURR_BASE | {6'd0, offset[19:10]};
    lo_unit = LO_SURR_BASE | {6'd0, offset[9:0]};
    case (head.job.op)
      OP_UNIT: begin
        unit_word.code_unit   = head.job.value[15:0];
        unit_word.last_of_run = 1'b1;
      end
      OP_PAIR: begin
        unit_word.code_unit   = half ? lo_unit : hi_unit;
        unit_word.last_of_run = half;
      end
      OP_REPL_UNIT: begin
        unit_word.code_unit   = half ? head.job.value[15:0] : REPL_UNIT;
        unit_word.last_of_run = half;
      end
      OP_REPL_REPL: begin
        unit_word.code_unit   = REPL_UNIT;
        unit_word.last_of_run = half;
      end
      default: begin
        unit_word.code_unit   = REPL_UNIT;
        unit_word.last_of_run = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      half <= 1'b0;
    end else if (accept) begin
      half <= !unit_word.last_of_run;
    end
  end

  `U8U16_ASSERT(half_has_head, clk, rst, half |-> head.avail)
  `U8U16_ASSERT(half_two_word_op, clk, rst,
    half |-> (head.job.op == OP_PAIR || head.job.op == OP_REPL_UNIT ||
              head.job.op == OP_REPL_REPL))
  `U8U16_ASSERT(second_word_follows, clk, rst,
    (accept && !unit_word.last_of_run) |=> (unit_valid && half))

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// utf8_to_utf16_decoder testbench
// Feeds UTF-8 byte words, first a short directed set and then random source
// buffers (mostly well-formed text, with malformed and truncated sequences
// mixed in). Each accepted byte is decoded by a local model of the decoder,
// and every output word is compared with the oldest predicted UTF-16 unit.
// Both handshakes idle at random, except while bytes_taken is from 300 to 549.
// ---------------------------------------------------------------------------
module testbench;
  import u8u16_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int FIRST_HALF  = 625;
  localparam int TOTAL_BYTES = 1225;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_stall;
  in_word_t  byte_word = '0;
  logic      unit_valid;
  logic      unit_stall = 1'b0;
  out_word_t unit_word;

  utf8_to_utf16_decoder i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_word  (unit_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  in_word_t    pending_bytes[$];
  out_word_t   expected_units[$];
  logic [7:0]  src[$];
  logic [15:0] step_units[$];
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          mismatches = 0;
  int          cycle_count = 0;
  logic        calm;

  // decoder model state
  logic        seq_busy = 1'b0;
  logic [1:0]  conts_left = 2'd0;
  logic [1:0]  seq_len = 2'd0;
  logic [20:0] acc_value = 21'd0;

  assign calm = (bytes_taken >= 300) && (bytes_taken < 550);

  task automatic clear_sequence();
    seq_busy   = 1'b0;
    conts_left = 2'd0;
    seq_len    = 2'd0;
    acc_value  = 21'd0;
  endtask

  task automatic start_lead(input logic [7:0] b, input logic [2:0] left);
    logic [1:0] len;
    logic [7:0] mask;
    if (b < 8'h80) begin
      step_units.push_back({8'h00, b});
      return;
    end
    if (b >= 8'hC2 && b <= 8'hDF) begin
      len = 2'd1;
      mask = 8'h1F;
    end else if (b >= 8'hE0 && b <= 8'hEF) begin
      len = 2'd2;
      mask = 8'h0F;
    end else if (b >= 8'hF0 && b <= 8'hF4) begin
      len = 2'd3;
      mask = 8'h07;
    end else begin
      step_units.push_back(REPL_UNIT);
      return;
    end
    // not enough source bytes left for the whole sequence
    if (left <= {1'b0, len}) begin
      step_units.push_back(REPL_UNIT);
      return;
    end
    seq_busy   = 1'b1;
    conts_left = len;
    seq_len    = len;
    acc_value  = {13'd0, b & mask};
  endtask

  task automatic decode_byte(input in_word_t w);
    logic [7:0]  low;
    logic [20:0] v;
    logic [19:0] offset;
    bit          relead;
    out_word_t   unit;
    step_units.delete();
    relead = 1'b0;
    if (seq_busy) begin
      low = w.data_byte ^ CONT_MARK;
      v = {acc_value[14:0], low[5:0]};
      if (low >= 8'h40) begin
        step_units.push_back(REPL_UNIT);
        clear_sequence();
        relead = 1'b1;
      end else if (conts_left == 2'd3) begin
        if (v < OVERLONG4_PART) begin
          step_units.push_back(REPL_UNIT);
          clear_sequence();
        end else begin
          acc_value = v;
          conts_left = 2'd2;
        end
      end else if (conts_left == 2'd2) begin
        if (v >= LIMIT_PART) begin
          step_units.push_back(REPL_UNIT);
          clear_sequence();
          relead = 1'b1;
        end else if (v < OVERLONG3_PART || (v >= SURR_PART_LO && v <= SURR_PART_HI)) begin
          step_units.push_back(REPL_UNIT);
          clear_sequence();
        end else begin
          acc_value = v;
          conts_left = 2'd1;
        end
      end else begin
        clear_sequence();
        if (v < OVERLONG2_VAL) begin
          step_units.push_back(REPL_UNIT);
        end else if (v <= BMP_MAX) begin
          step_units.push_back(v[15:0]);
        end else begin
          offset = 20'(v - SUPP_BASE);
          step_units.push_back(HI_SURR_BASE | {6'd0, offset[19:10]});
          step_units.push_back(LO_SURR_BASE | {6'd0, offset[9:0]});
        end
      end
      if (relead) start_lead(w.data_byte, w.bytes_left);
    end else begin
      start_lead(w.data_byte, w.bytes_left);
    end
    foreach (step_units[i]) begin
      unit.code_unit = step_units[i];
      unit.last_of_run = (i == step_units.size() - 1);
      expected_units.push_back(unit);
    end
  endtask

  // encodes cp in len bytes, overlong or out of range if asked to
  task automatic put_char(input int cp, input int len);
    int lead_mark;
    if (len == 1) begin
      src.push_back(8'(cp));
      return;
    end
    lead_mark = (len == 2) ? 'hC0 : (len == 3) ? 'hE0 : 'hF0;
    src.push_back(8'(lead_mark | (cp >> (6 * (len - 1)))));
    for (int k = len - 2; k >= 0; k--)
      src.push_back(8'('h80 | ((cp >> (6 * k)) & 'h3F)));
  endtask

  task automatic put_valid(input int len);
    int cp;
    if (len == 2) begin
      cp = $urandom_range('h80, 'h7FF);
    end else if (len == 3) begin
      cp = $urandom_range('h800, 'hFFFF);
      if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h2000;
    end else begin
      cp = $urandom_range('h10000, 'h10FFFF);
    end
    put_char(cp, len);
  endtask

  task automatic add_char();
    int kind;
    int len;
    int pos;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind < 30) begin
      put_char($urandom_range(0, 'h7F), 1);
    end else if (kind < 50) begin
      put_valid(2);
    end else if (kind < 70) begin
      put_valid(3);
    end else if (kind < 85) begin
      put_valid(4);
    end else begin
      len = $urandom_range(2, 4);
      case ($urandom_range(0, 6))
        0: src.push_back(8'($urandom_range(0, 255)));
        1: put_char($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF), len);
        2: put_char($urandom_range('hD800, 'hDFFF), 3);
        3: put_char($urandom_range('h110000, 'h1FFFFF), 4);
        4: begin
          put_valid(len);
          repeat ($urandom_range(1, len - 1)) void'(src.pop_back());
        end
        5: begin
          put_valid(len);
          pos = src.size() - $urandom_range(1, len - 1);
          b = 8'($urandom_range(0, 255));
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          src[pos] = b;
        end
        default: src.push_back(8'('h80 | $urandom_range(0, 'h3F)));
      endcase
    end
  endtask

  // queues src as one source buffer; noisy buffers get random byte counts
  task automatic send_source(input bit noisy);
    in_word_t w;
    for (int i = 0; i < src.size(); i++) begin
      w.data_byte = src[i];
      if (noisy)
        w.bytes_left = 3'($urandom_range(0, 7));
      else
        w.bytes_left = (src.size() - i >= 4) ? 3'd4 : 3'(src.size() - i);
      pending_bytes.push_back(w);
      bytes_queued++;
    end
    src.delete();
  endtask

  task automatic add_buffer();
    repeat ($urandom_range(1, 8)) add_char();
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 2)) if (src.size() > 1) void'(src.pop_back());
    send_source($urandom_range(0, 19) == 0);
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || byte_valid || expected_units.size() != 0)
      @(posedge clk);
  endtask

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      if (byte_valid && !byte_stall) begin
        decode_byte(byte_word);
        bytes_taken++;
      end
      if (!byte_valid || !byte_stall) begin
        if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
          byte_word <= pending_bytes.pop_front();
          byte_valid <= 1'b1;
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // unit monitor
  always @(posedge clk) begin : unit_monitor
    out_word_t want;
    if (rst) begin
      unit_stall <= 1'b0;
    end else begin
      if (unit_valid && !unit_stall) begin
        if (expected_units.size() == 0) begin
          $display("%0t: unexpected word, code_unit %h last_of_run %b", $time,
                   unit_word.code_unit, unit_word.last_of_run);
          mismatches++;
        end else begin
          want = expected_units.pop_front();
          if (unit_word.code_unit !== want.code_unit) begin
            $display("%0t: code_unit expected %h got %h", $time,
                     want.code_unit, unit_word.code_unit);
            mismatches++;
          end
          if (unit_word.last_of_run !== want.last_of_run) begin
            $display("%0t: last_of_run expected %b got %b", $time,
                     want.last_of_run, unit_word.last_of_run);
            mismatches++;
          end
        end
      end
      unit_stall <= !calm && ($urandom_range(0, 99) < 25);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    in_word_t w;
    // ASCII extremes, the lowest two-byte form and the highest three- and four-byte forms
    src = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
            8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_source(1'b0);
    // bad leads, bad continuation, overlong, surrogate, over limit, past end
    src = '{8'h80, 8'hFF, 8'hC2, 8'h41, 8'hE0, 8'h80, 8'h80,
            8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'hC2};
    send_source(1'b0);
    w = '{data_byte: 8'hF0, bytes_left: 3'd0};
    pending_bytes.push_back(w);
    w = '{data_byte: 8'hE1, bytes_left: 3'd7};
    pending_bytes.push_back(w);
    w = '{data_byte: 8'h80, bytes_left: 3'd6};
    pending_bytes.push_back(w);
    w = '{data_byte: 8'h80, bytes_left: 3'd5};
    pending_bytes.push_back(w);
    while (bytes_queued < FIRST_HALF) add_buffer();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    wait_drained();
    while (bytes_queued < TOTAL_BYTES) add_buffer();
    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
